/* rtl/pcof_pkg.sv */
// Shared constants, register codes and sequencer states of the point cloud outlier filter.
`default_nettype none

package pcof_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned LIMIT_W        = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [LIMIT_W-1:0] Z_NEAR_RST  = 16'd576;
  localparam logic [LIMIT_W-1:0] XY_NEAR_RST = 16'd829;
  localparam logic [LIMIT_W-1:0] MIRROR_RST  = 16'd576;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Z_NEAR  = 2'd0,
    REG_XY_NEAR = 2'd1,
    REG_MIRROR  = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3,
    ST_PRE0, ST_PRE1, ST_PRE2, ST_PRE3, ST_PRE4, ST_PRE5, ST_PRE6, ST_PRE7, ST_PRE8,
    ST_RD, ST_LD,
    ST_AX0, ST_AX1, ST_AX2, ST_AX3, ST_AX4, ST_AX5, ST_AX6,
    ST_EMIT, ST_FLUSH
  } state_e;

endpackage

`default_nettype wire

/* rtl/pcof_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module pcof_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/point_cloud_outlier_filter.sv */
// Point load: per beat, accept, then four sequencer steps for x^2, y^2, z^2.
// Filter start: the PRE steps form N*Q - S^2 and both limit products for each of the three axes.
// Scan: a store read per point, then the AX steps per axis tested (a failing axis ends the
// point early); an emit step per kept point but the last, a flush step per cloud, both
// held by output stalls. One item in flight; results leave registered.
// Reset: limits to defaults, point count and sums to zero; the point store is not cleared.
`default_nettype none

module point_cloud_outlier_filter #(
  parameter int unsigned MAX_POINTS = pcof_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = pcof_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]         pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]         pos_y_i,
  input  wire logic signed [COORD_BITS-1:0]         pos_z_i,
  input  wire logic                                 final_point_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [COORD_BITS-1:0]              kept_x_o,
  output logic signed [COORD_BITS-1:0]              kept_y_o,
  output logic signed [COORD_BITS-1:0]              kept_z_o,
  output logic                                      run_end_o,
  output logic                                      none_kept_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [pcof_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [pcof_pkg::LIMIT_W-1:0]         cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned S_W   = COORD_BITS + CNT_W;
  localparam int unsigned D_W   = COORD_BITS + CNT_W + 1;
  localparam int unsigned MUL_W = (D_W > pcof_pkg::LIMIT_W) ? D_W : pcof_pkg::LIMIT_W;
  localparam int unsigned P_W   = 2 * MUL_W;
  localparam int unsigned Q_W   = 2 * COORD_BITS + CNT_W;
  localparam int unsigned ACC_W = P_W + pcof_pkg::LIMIT_W + 1;
  localparam int unsigned PT_W  = 3 * COORD_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  pcof_pkg::state_e state_q, state_d;

  logic [pcof_pkg::LIMIT_W-1:0] z_lim_q, xy_lim_q, mir_lim_q;

  logic [CNT_W-1:0]             cnt_q, idx_q;
  logic [1:0]                   ax_q;
  logic                         fin_q, stored_q;
  logic signed [S_W-1:0]        sum_q [3];
  logic [Q_W-1:0]               sq_q [3];
  logic [COORD_BITS-1:0]        mag_q [3];
  logic [PT_W-1:0]              pt_q;
  logic [P_W-1:0]               prod_q;
  logic [ACC_W-1:0]             acc_q, rhs_q;
  logic [ACC_W-1:0]             rhs_near_q [3];
  logic [ACC_W-1:0]             rhs_mir_q [3];
  logic [S_W-1:0]               smag_q;
  logic signed [D_W-1:0]        np_q, d1_q, d2_q;
  logic [D_W-1:0]               dm1_q, dm2_q;
  logic                         pass1_q;
  logic                         pend_v_q;
  logic [PT_W-1:0]              pend_pt_q;
  logic                         out_valid_q, out_end_q, out_none_q;
  logic [PT_W-1:0]              out_pt_q;

  logic signed [COORD_BITS-1:0] pos_in [3];
  logic signed [COORD_BITS-1:0] pt_c [3];
  logic signed [COORD_BITS-1:0] rd_c [3];
  logic [PT_W-1:0]              ram_rdata;
  logic [MUL_W-1:0]             mul_a, mul_b;
  logic [P_W-1:0]               q_ext;
  logic [pcof_pkg::LIMIT_W-1:0] near_lim;
  logic                         in_acc, store_ok, out_free, near_lt, mir_lt, pass_now, last_pt;
  logic                         ram_we, out_load;

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_c[k] = pt_q[k*COORD_BITS +: COORD_BITS];
      rd_c[k] = ram_rdata[k*COORD_BITS +: COORD_BITS];
    end
  end

  assign in_stall_o  = (state_q != pcof_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign store_ok    = (cnt_q != MAX_CNT);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_ext       = P_W'(sq_q[ax_q]);
  assign near_lim    = (ax_q == 2'd2) ? z_lim_q : xy_lim_q;
  assign near_lt     = ACC_W'({prod_q, 8'd0}) < rhs_near_q[ax_q];
  assign mir_lt      = ACC_W'({prod_q, 8'd0}) < rhs_mir_q[ax_q];
  assign pass_now    = pass1_q || mir_lt;
  assign last_pt     = (CNT_W'(idx_q + 1'b1) == cnt_q);
  assign cfg_ready_o = 1'b1;

  pcof_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcof_pkg::ST_IDLE:  if (in_acc) state_d = pcof_pkg::ST_SQ0;
      pcof_pkg::ST_SQ0:   state_d = pcof_pkg::ST_SQ1;
      pcof_pkg::ST_SQ1:   state_d = pcof_pkg::ST_SQ2;
      pcof_pkg::ST_SQ2:   state_d = pcof_pkg::ST_SQ3;
      pcof_pkg::ST_SQ3:   state_d = fin_q ? pcof_pkg::ST_PRE0 : pcof_pkg::ST_IDLE;
      pcof_pkg::ST_PRE0:  state_d = pcof_pkg::ST_PRE1;
      pcof_pkg::ST_PRE1:  state_d = pcof_pkg::ST_PRE2;
      pcof_pkg::ST_PRE2:  state_d = pcof_pkg::ST_PRE3;
      pcof_pkg::ST_PRE3:  state_d = pcof_pkg::ST_PRE4;
      pcof_pkg::ST_PRE4:  state_d = pcof_pkg::ST_PRE5;
      pcof_pkg::ST_PRE5:  state_d = pcof_pkg::ST_PRE6;
      pcof_pkg::ST_PRE6:  state_d = pcof_pkg::ST_PRE7;
      pcof_pkg::ST_PRE7:  state_d = pcof_pkg::ST_PRE8;
      pcof_pkg::ST_PRE8:  state_d = (ax_q == 2'd2) ? pcof_pkg::ST_RD : pcof_pkg::ST_PRE0;
      pcof_pkg::ST_RD:    state_d = pcof_pkg::ST_LD;
      pcof_pkg::ST_LD:    state_d = pcof_pkg::ST_AX0;
      pcof_pkg::ST_AX0:   state_d = pcof_pkg::ST_AX1;
      pcof_pkg::ST_AX1:   state_d = pcof_pkg::ST_AX2;
      pcof_pkg::ST_AX2:   state_d = pcof_pkg::ST_AX3;
      pcof_pkg::ST_AX3:   state_d = pcof_pkg::ST_AX4;
      pcof_pkg::ST_AX4:   state_d = pcof_pkg::ST_AX5;
      pcof_pkg::ST_AX5:   state_d = pcof_pkg::ST_AX6;
      pcof_pkg::ST_AX6: begin
        if (pass_now && ax_q != 2'd2) begin
          state_d = pcof_pkg::ST_AX0;
        end else if (pass_now && pend_v_q) begin
          state_d = pcof_pkg::ST_EMIT;
        end else begin
          state_d = last_pt ? pcof_pkg::ST_FLUSH : pcof_pkg::ST_RD;
        end
      end
      pcof_pkg::ST_EMIT: begin
        if (out_free) state_d = last_pt ? pcof_pkg::ST_FLUSH : pcof_pkg::ST_RD;
      end
      pcof_pkg::ST_FLUSH: if (out_free) state_d = pcof_pkg::ST_IDLE;
      default:            state_d = pcof_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, store write, output load.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pcof_pkg::ST_IDLE:  ram_we = in_acc && store_ok;
      pcof_pkg::ST_SQ0: begin
        mul_a = MUL_W'(mag_q[0]);
        mul_b = MUL_W'(mag_q[0]);
      end
      pcof_pkg::ST_SQ1: begin
        mul_a = MUL_W'(mag_q[1]);
        mul_b = MUL_W'(mag_q[1]);
      end
      pcof_pkg::ST_SQ2: begin
        mul_a = MUL_W'(mag_q[2]);
        mul_b = MUL_W'(mag_q[2]);
      end
      pcof_pkg::ST_PRE0: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = q_ext[MUL_W-1:0];
      end
      pcof_pkg::ST_PRE1: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = q_ext[P_W-1:MUL_W];
      end
      pcof_pkg::ST_PRE2: begin
        mul_a = MUL_W'(smag_q);
        mul_b = MUL_W'(smag_q);
      end
      pcof_pkg::ST_PRE4: begin
        mul_a = acc_q[MUL_W-1:0];
        mul_b = MUL_W'(near_lim);
      end
      pcof_pkg::ST_PRE5: begin
        mul_a = acc_q[P_W-1:MUL_W];
        mul_b = MUL_W'(near_lim);
      end
      pcof_pkg::ST_PRE6: begin
        mul_a = acc_q[MUL_W-1:0];
        mul_b = MUL_W'(mir_lim_q);
      end
      pcof_pkg::ST_PRE7: begin
        mul_a = acc_q[P_W-1:MUL_W];
        mul_b = MUL_W'(mir_lim_q);
      end
      pcof_pkg::ST_AX0: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = MUL_W'(mag_q[ax_q]);
      end
      pcof_pkg::ST_AX4: begin
        mul_a = MUL_W'(dm1_q);
        mul_b = MUL_W'(dm1_q);
      end
      pcof_pkg::ST_AX5: begin
        mul_a = MUL_W'(dm2_q);
        mul_b = MUL_W'(dm2_q);
      end
      pcof_pkg::ST_EMIT, pcof_pkg::ST_FLUSH: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_lim_q   <= pcof_pkg::Z_NEAR_RST;
      xy_lim_q  <= pcof_pkg::XY_NEAR_RST;
      mir_lim_q <= pcof_pkg::MIRROR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pcof_pkg::reg_idx_e'(cfg_index_i))
        pcof_pkg::REG_Z_NEAR:  z_lim_q   <= cfg_data_i;
        pcof_pkg::REG_XY_NEAR: xy_lim_q  <= cfg_data_i;
        pcof_pkg::REG_MIRROR:  mir_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcof_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      ax_q        <= '0;
      fin_q       <= 1'b0;
      stored_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        sq_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        pcof_pkg::ST_IDLE: begin
          if (in_acc) begin
            fin_q    <= final_point_i;
            stored_q <= store_ok;
            if (store_ok) begin
              cnt_q <= CNT_W'(cnt_q + 1'b1);
              for (int k = 0; k < 3; k++) begin
                sum_q[k] <= sum_q[k] + S_W'(pos_in[k]);
              end
            end
          end
        end
        pcof_pkg::ST_SQ1: if (stored_q) sq_q[0] <= sq_q[0] + Q_W'(prod_q);
        pcof_pkg::ST_SQ2: if (stored_q) sq_q[1] <= sq_q[1] + Q_W'(prod_q);
        pcof_pkg::ST_SQ3: begin
          if (stored_q) sq_q[2] <= sq_q[2] + Q_W'(prod_q);
          ax_q <= '0;
        end
        pcof_pkg::ST_PRE8: begin
          ax_q     <= (ax_q == 2'd2) ? 2'd0 : 2'(ax_q + 1'b1);
          idx_q    <= '0;
          pend_v_q <= 1'b0;
        end
        pcof_pkg::ST_LD: ax_q <= '0;
        pcof_pkg::ST_AX6: begin
          if (pass_now && ax_q != 2'd2) begin
            ax_q <= 2'(ax_q + 1'b1);
          end else begin
            if (pass_now && !pend_v_q) pend_v_q <= 1'b1;
            // advance now unless the pending point still has to go out first
            if (!(pass_now && pend_v_q)) idx_q <= CNT_W'(idx_q + 1'b1);
          end
        end
        pcof_pkg::ST_EMIT: if (out_free) idx_q <= CNT_W'(idx_q + 1'b1);
        pcof_pkg::ST_FLUSH: begin
          if (out_free) begin
            cnt_q    <= '0;
            pend_v_q <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              sum_q[k] <= '0;
              sq_q[k]  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      pcof_pkg::ST_IDLE: begin
        for (int k = 0; k < 3; k++) begin
          mag_q[k] <= pos_in[k][COORD_BITS-1] ? COORD_BITS'(-pos_in[k]) : COORD_BITS'(pos_in[k]);
        end
      end
      pcof_pkg::ST_PRE0: begin
        smag_q <= sum_q[ax_q][S_W-1] ? S_W'(-sum_q[ax_q]) : S_W'(sum_q[ax_q]);
      end
      pcof_pkg::ST_PRE1: acc_q <= ACC_W'(prod_q);
      pcof_pkg::ST_PRE2: acc_q <= acc_q + (ACC_W'(prod_q) << MUL_W);
      pcof_pkg::ST_PRE3: acc_q <= acc_q - ACC_W'(prod_q);
      pcof_pkg::ST_PRE5: rhs_q <= ACC_W'(prod_q);
      pcof_pkg::ST_PRE6: rhs_near_q[ax_q] <= rhs_q + (ACC_W'(prod_q) << MUL_W);
      pcof_pkg::ST_PRE7: rhs_q <= ACC_W'(prod_q);
      pcof_pkg::ST_PRE8: rhs_mir_q[ax_q] <= rhs_q + (ACC_W'(prod_q) << MUL_W);
      pcof_pkg::ST_LD: begin
        pt_q <= ram_rdata;
        for (int k = 0; k < 3; k++) begin
          mag_q[k] <= rd_c[k][COORD_BITS-1] ? COORD_BITS'(-rd_c[k]) : COORD_BITS'(rd_c[k]);
        end
      end
      pcof_pkg::ST_AX1: begin
        np_q <= pt_c[ax_q][COORD_BITS-1] ? -D_W'(prod_q) : D_W'(prod_q);
      end
      pcof_pkg::ST_AX2: begin
        d1_q <= np_q - D_W'(sum_q[ax_q]);
        d2_q <= np_q + D_W'(sum_q[ax_q]);
      end
      pcof_pkg::ST_AX3: begin
        dm1_q <= d1_q[D_W-1] ? D_W'(-d1_q) : D_W'(d1_q);
        dm2_q <= d2_q[D_W-1] ? D_W'(-d2_q) : D_W'(d2_q);
      end
      pcof_pkg::ST_AX5: pass1_q <= near_lt;
      pcof_pkg::ST_AX6: begin
        // hold the newest kept point back until we know whether it is the last
        if (pass_now && ax_q == 2'd2 && !pend_v_q) pend_pt_q <= pt_q;
      end
      pcof_pkg::ST_EMIT: begin
        if (out_free) begin
          out_pt_q   <= pend_pt_q;
          out_end_q  <= 1'b0;
          out_none_q <= 1'b0;
          pend_pt_q  <= pt_q;
        end
      end
      pcof_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_pt_q   <= pend_v_q ? pend_pt_q : '0;
          out_end_q  <= 1'b1;
          out_none_q <= !pend_v_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign kept_x_o    = out_pt_q[0*COORD_BITS +: COORD_BITS];
  assign kept_y_o    = out_pt_q[1*COORD_BITS +: COORD_BITS];
  assign kept_z_o    = out_pt_q[2*COORD_BITS +: COORD_BITS];
  assign run_end_o   = out_end_q;
  assign none_kept_o = out_none_q;

endmodule

`default_nettype wire

/* rtl/pcof_checker.sv */
// Port-level checks of the point cloud outlier filter, bound to its top level.
`default_nettype none

module pcof_checker #(
  parameter int unsigned COORD_BITS = pcof_pkg::COORD_BITS_DEF
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [COORD_BITS-1:0] kept_x_o,
  input wire logic [COORD_BITS-1:0] kept_y_o,
  input wire logic [COORD_BITS-1:0] kept_z_o,
  input wire logic                  run_end_o,
  input wire logic                  none_kept_o
);

  a_none_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_kept_o |-> run_end_o)
    else $error("empty result without run end");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_kept_o |-> kept_x_o == '0 && kept_y_o == '0 && kept_z_o == '0)
    else $error("empty result with nonzero coordinates");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the previous beat was processed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kept_x_o) && $stable(run_end_o))
    else $error("stalled result changed");

endmodule

bind point_cloud_outlier_filter pcof_checker #(
  .COORD_BITS (COORD_BITS)
) u_pcof_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kept_x_o    (kept_x_o),
  .kept_y_o    (kept_y_o),
  .kept_z_o    (kept_z_o),
  .run_end_o   (run_end_o),
  .none_kept_o (none_kept_o)
);

`default_nettype wire
